// ===== rtl/core/symmetric_tensor_packed_index_macros.svh =====
// Assertion macros shared by the packed index RTL.
// Needs clk and arst_n in the scope where they are used.
`ifndef SYMMETRIC_TENSOR_PACKED_INDEX_MACROS_SVH
`define SYMMETRIC_TENSOR_PACKED_INDEX_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STPI_ASSERT_HOLD(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STPI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/stpi_pkg.sv =====
// Types and constants for the symmetric tensor packed index block.
// No dependencies; imported by symmetric_tensor_packed_index.
package stpi_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_A = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_B = 2'd2;

	// Dimension registers compared against indices in this width
	localparam int DIM_CMP_W = 11;

	typedef enum logic [1:0] {
		SYM_EIGHT_EVEN = 2'd0,
		SYM_EIGHT_ODD  = 2'd1,
		SYM_FOUR_ODD   = 2'd2,
		SYM_FOUR_EVEN  = 2'd3
	} sym_mode_t;

	// Beat payloads
	typedef struct packed {
		logic [7:0] idx_p;
		logic [7:0] idx_q;
		logic [7:0] idx_r;
		logic [7:0] idx_s;
	} in_item_t;

	typedef struct packed {
		logic [30:0] offset;
		logic        negate;
		logic        out_of_range;
	} out_item_t;

	localparam logic [30:0] OFFSET_MAX = 31'h7FFF_FFFF;

	// I(I+1)(I+2)(3I+1)/24 for every 8-bit I; largest entry is below 2^30
	localparam int QUART_W = 30;
	typedef logic [255:0][QUART_W-1:0] quart_tbl_t;

	function automatic quart_tbl_t quart_build();
		quart_tbl_t  t;
		logic [63:0] n;
		logic [63:0] v;
		for (int i = 0; i < 256; i++) begin
			n = 64'(i);
			v = (n * (n + 64'd1) * (n + 64'd2) * (64'd3 * n + 64'd1)) / 64'd24;
			t[i] = v[QUART_W-1:0];
		end
		return t;
	endfunction

	localparam quart_tbl_t QUART_TBL = quart_build();

endpackage

// ===== rtl/core/symmetric_tensor_packed_index.sv =====
// Packed storage offset and sign generator for a pair-symmetric 4-index tensor.
// Depends on stpi_pkg and symmetric_tensor_packed_index_macros.svh.
//
//   channel | signals                          | moves
//   --------+----------------------------------+------------------------------
//   in      | in_valid, in_stall, in_data      | one index tuple per beat
//   out     | out_valid, out_stall, out_data   | offset, negate, range flag
//   cfg     | cfg_we, cfg_idx, cfg_wdata       | register write, no read-back
//
// One beat per cycle in each direction while out is not stalled, through the
// four register stages (order/check, triangle terms, multiply, add/saturate).
// Reset clears the stage valid bits and loads mode 0, dim_a 1, dim_b 1.
// A stall on out holds the full stages; empty stages ahead still fill, so in
// stalls only when all four stages hold a beat and out is stalled.
module symmetric_tensor_packed_index
	import stpi_pkg::*;
#(
	parameter int MAX_DIM = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "symmetric_tensor_packed_index_macros.svh"

	localparam int CDW = $clog2(MAX_DIM + 1);

	function automatic logic [CDW-1:0] clamp_dim(logic [CFG_DATA_W-1:0] d);
		logic [DIM_CMP_W-1:0] w;
		w = (DIM_CMP_W'(d) > DIM_CMP_W'(MAX_DIM)) ? DIM_CMP_W'(MAX_DIM) : DIM_CMP_W'(d);
		return w[CDW-1:0];
	endfunction

	// Configuration registers
	sym_mode_t             mode_q;
	logic [CFG_DATA_W-1:0] dim_a_q;
	logic [CFG_DATA_W-1:0] dim_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= SYM_EIGHT_EVEN;
			dim_a_q <= CFG_DATA_W'(1);
			dim_b_q <= CFG_DATA_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE:  mode_q  <= sym_mode_t'(cfg_wdata[1:0]);
				REG_DIM_A: dim_a_q <= cfg_wdata;
				REG_DIM_B: dim_b_q <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	logic [CDW-1:0] da_c;
	logic [CDW-1:0] db_c;
	logic           eight;
	logic           odd;

	assign da_c  = clamp_dim(dim_a_q);
	assign db_c  = clamp_dim(dim_b_q);
	assign eight = (mode_q == SYM_EIGHT_EVEN) || (mode_q == SYM_EIGHT_ODD);
	assign odd   = (mode_q == SYM_EIGHT_ODD) || (mode_q == SYM_FOUR_ODD);

	// Stage enables: a stage loads when it is empty or the next one moves
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4    = !v_s4 || !out_stall;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: range check, pair ordering, pair exchange
	logic [DIM_CMP_W-1:0] da_w, db_w;
	logic                 bad;
	logic                 sw1, sw2, xchg;
	logic [7:0]           h1, l1, h2, l2;

	always_comb begin
		da_w = DIM_CMP_W'(da_c);
		db_w = DIM_CMP_W'(db_c);
		if (eight) begin
			bad = (DIM_CMP_W'(in_data.idx_p) >= da_w) || (DIM_CMP_W'(in_data.idx_q) >= da_w)
				|| (DIM_CMP_W'(in_data.idx_r) >= da_w) || (DIM_CMP_W'(in_data.idx_s) >= da_w);
		end else begin
			bad = (DIM_CMP_W'(in_data.idx_p) >= da_w) || (DIM_CMP_W'(in_data.idx_q) >= da_w)
				|| (DIM_CMP_W'(in_data.idx_r) >= db_w) || (DIM_CMP_W'(in_data.idx_s) >= db_w);
		end
		sw1  = in_data.idx_q > in_data.idx_p;
		sw2  = in_data.idx_s > in_data.idx_r;
		h1   = sw1 ? in_data.idx_q : in_data.idx_p;
		l1   = sw1 ? in_data.idx_p : in_data.idx_q;
		h2   = sw2 ? in_data.idx_s : in_data.idx_r;
		l2   = sw2 ? in_data.idx_r : in_data.idx_s;
		xchg = eight && (h2 > h1);
	end

	logic [7:0] hi_i_s1, lo_j_s1, hi_k_s1, lo_l_s1;
	logic       neg_s1, bad_s1, eight_s1;

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			hi_i_s1  <= xchg ? h2 : h1;
			lo_j_s1  <= xchg ? l2 : l1;
			hi_k_s1  <= xchg ? h1 : h2;
			lo_l_s1  <= xchg ? l1 : l2;
			neg_s1   <= odd && (sw1 ^ sw2);
			bad_s1   <= bad;
			eight_s1 <= eight;
		end
	end

	// Stage 2: triangle numbers and quartic table, multiplier operand select
	logic [8:0]  ip1, ip2;
	logic [16:0] ip_prod;
	logic [15:0] t_ip1, t_i;
	logic [15:0] k_prod, tk;
	logic [17:0] db_prod;
	logic [16:0] t_db;

	always_comb begin
		ip1     = 9'(hi_i_s1) + 9'd1;
		ip2     = 9'(hi_i_s1) + 9'd2;
		ip_prod = 17'(ip1) * 17'(ip2);
		t_ip1   = ip_prod[16:1];
		t_i     = t_ip1 - 16'(ip1);
		k_prod  = 16'(hi_k_s1) * (16'(hi_k_s1) + 16'd1);
		tk      = 16'(k_prod[15:1]) + 16'(lo_l_s1);
		db_prod = 18'(db_c) * (18'(db_c) + 18'd1);
		t_db    = db_prod[17:1];
	end

	logic [15:0]        mul_a_s2;
	logic [16:0]        mul_b_s2;
	logic [QUART_W-1:0] base_s2;
	logic [15:0]        tk_s2;
	logic               neg_s2, bad_s2;

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			mul_a_s2 <= eight_s1 ? 16'(lo_j_s1) : t_i + 16'(lo_j_s1);
			mul_b_s2 <= eight_s1 ? 17'(t_ip1) : t_db;
			base_s2  <= eight_s1 ? QUART_TBL[hi_i_s1] : '0;
			tk_s2    <= tk;
			neg_s2   <= neg_s1;
			bad_s2   <= bad_s1;
		end
	end

	// Stage 3: the wide multiply of the selected operands
	logic [32:0]        prod_s3;
	logic [QUART_W-1:0] base_s3;
	logic [15:0]        tk_s3;
	logic               neg_s3, bad_s3;

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			prod_s3 <= 33'(mul_a_s2) * 33'(mul_b_s2);
			base_s3 <= base_s2;
			tk_s3   <= tk_s2;
			neg_s3  <= neg_s2;
			bad_s3  <= bad_s2;
		end
	end

	// Stage 4: final sum, saturation, zeroing of out-of-range beats
	logic [34:0] sum;
	logic [30:0] sat;

	always_comb begin
		sum = 35'(prod_s3) + 35'(base_s3) + 35'(tk_s3);
		sat = (sum > 35'(OFFSET_MAX)) ? OFFSET_MAX : sum[30:0];
	end

	out_item_t item_s4;

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			item_s4.offset       <= bad_s3 ? '0 : sat;
			item_s4.negate       <= !bad_s3 && neg_s3;
			item_s4.out_of_range <= bad_s3;
		end
	end

	assign out_data = item_s4;

	// Checks on the pipeline control and result fields
	`STPI_ASSERT_HOLD(a_stall_full, in_stall,
		v_s1 && v_s2 && v_s3 && v_s4 && out_stall, "input stalled with a free stage")
	`STPI_ASSERT_NEXT(a_accept_s1, in_valid && !in_stall, v_s1,
		"accepted beat did not reach stage 1")
	`STPI_ASSERT_NEXT(a_hold_s3, v_s3 && !en_s4, v_s3 && $stable(prod_s3),
		"stage 3 lost or changed a held beat")
	`STPI_ASSERT_HOLD(a_oor_zero, out_valid && out_data.out_of_range,
		out_data.offset == '0 && !out_data.negate, "out-of-range beat carries data")

endmodule
